/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the expression lexer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AEL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AEL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ael_pkg.sv */
// ----------------------------------------------------------------------------
// ael_pkg
// Types, character codes and keyword tables of the expression lexer.
// ----------------------------------------------------------------------------
package ael_pkg;

    localparam int POS_BITS  = 16;
    localparam int KW_NUM    = 6;
    localparam int KW_CHARS  = 3;
    localparam int TOK_DEPTH = 2;
    localparam int PTR_BITS  = (TOK_DEPTH > 1) ? $clog2(TOK_DEPTH) : 1;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [KW_NUM-1:0] CAND_ALL = {KW_NUM{1'b1}};

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LOW_A = 8'd97;
    localparam logic [7:0] CH_LOW_Z = 8'd122;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_NUMBER = 2'd1,
        RUN_WORD   = 2'd2
    } t_run_mode;

    typedef enum logic [3:0] {
        KIND_PLUS   = 4'd0,
        KIND_MINUS  = 4'd1,
        KIND_MUL    = 4'd2,
        KIND_DIV    = 4'd3,
        KIND_LPAREN = 4'd4,
        KIND_RPAREN = 4'd5,
        KIND_NUMBER = 4'd6,
        KIND_SIN    = 4'd7,
        KIND_COS    = 4'd8,
        KIND_TAN    = 4'd9,
        KIND_EXP    = 4'd10,
        KIND_LOG    = 4'd11
    } t_token_kind;

    // Keywords: sin, cos, tan, exp, log, ln
    localparam logic [7:0] KW_TEXT [KW_NUM][KW_CHARS] = '{
        '{8'h73, 8'h69, 8'h6E},
        '{8'h63, 8'h6F, 8'h73},
        '{8'h74, 8'h61, 8'h6E},
        '{8'h65, 8'h78, 8'h70},
        '{8'h6C, 8'h6F, 8'h67},
        '{8'h6C, 8'h6E, 8'h00}
    };
    localparam logic [1:0] KW_LEN [KW_NUM] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2};
    localparam t_token_kind KW_KIND [KW_NUM] = '{
        KIND_SIN, KIND_COS, KIND_TAN, KIND_EXP, KIND_LOG, KIND_LOG
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_token_kind token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] token_ordinal;
        logic        word_recognized;
        logic        last_of_run;
    } t_out_item;

    // Tokens produced by one byte, handed from the step logic to the queue.
    typedef struct packed {
        logic      valid;
        logic      pair;
        t_out_item tok0;
        t_out_item tok1;
    } t_tok_pair;

endpackage

/* rtl/core/ael_step.sv */
// ----------------------------------------------------------------------------
// ael_step
// Input register, run state and the per-byte tokenizing logic.
// ----------------------------------------------------------------------------
module ael_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ael_pkg::t_in_item i_in_data,
    input  logic              i_room,
    output ael_pkg::t_tok_pair o_pair
);

    typedef struct packed {
        logic                rec;
        ael_pkg::t_token_kind kind;
    } t_word_res;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ael_pkg::CH_ZERO) && (c <= ael_pkg::CH_NINE);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= ael_pkg::CH_LOW_A) && (c <= ael_pkg::CH_LOW_Z);
    endfunction

    function automatic logic [ael_pkg::KW_NUM-1:0] first_cand(input logic [7:0] c);
        logic [ael_pkg::KW_NUM-1:0] m;
        for (int i = 0; i < ael_pkg::KW_NUM; i++) begin
            m[i] = (ael_pkg::KW_TEXT[i][0] == c);
        end
        return m;
    endfunction

    // Lowest-numbered keyword whose full length matches wins.
    function automatic t_word_res close_word(input logic [ael_pkg::KW_NUM-1:0] cand,
                                             input logic [15:0] len);
        t_word_res res;
        res.rec  = 1'b0;
        res.kind = ael_pkg::KIND_SIN;
        for (int i = ael_pkg::KW_NUM - 1; i >= 0; i--) begin
            if (cand[i] && (len == 16'(ael_pkg::KW_LEN[i]))) begin
                res.rec  = 1'b1;
                res.kind = ael_pkg::KW_KIND[i];
            end
        end
        return res;
    endfunction

    function automatic ael_pkg::t_out_item make_tok(input ael_pkg::t_token_kind kind,
                                                    input logic [ael_pkg::POS_BITS-1:0] start,
                                                    input logic [15:0] len,
                                                    input logic rec);
        ael_pkg::t_out_item t;
        t.token_kind      = kind;
        t.token_start     = 16'(start);
        t.token_length    = len;
        t.token_ordinal   = '0;
        t.word_recognized = rec;
        t.last_of_run     = 1'b0;
        return t;
    endfunction

    function automatic ael_pkg::t_out_item run_tok(input ael_pkg::t_run_mode mode,
                                                   input logic [ael_pkg::KW_NUM-1:0] cand,
                                                   input logic [ael_pkg::POS_BITS-1:0] start,
                                                   input logic [15:0] len);
        t_word_res w;
        w = close_word(cand, len);
        if (mode == ael_pkg::RUN_WORD) begin
            return make_tok(w.kind, start, len, w.rec);
        end
        return make_tok(ael_pkg::KIND_NUMBER, start, len, 1'b1);
    endfunction

    // input register
    logic               r_in_vld;
    ael_pkg::t_in_item  r_in;

    // run state
    ael_pkg::t_run_mode            r_mode,      n_mode;
    logic [ael_pkg::POS_BITS-1:0]  r_run_start, n_run_start;
    logic [15:0]                   r_run_len,   n_run_len;
    logic [ael_pkg::KW_NUM-1:0]    r_cand,      n_cand;
    logic [ael_pkg::POS_BITS-1:0]  r_pos,       n_pos;
    logic [15:0]                   r_tok_cnt,   n_tok_cnt;

    logic                          adv;
    logic [7:0]                    c;
    logic                          eos;
    logic                          c_digit;
    logic                          c_lower;
    logic                          is_op;
    ael_pkg::t_token_kind          op_kind;
    logic                          extended;
    logic                          close_old;
    logic                          op_emit;
    logic                          close_new;
    logic [ael_pkg::KW_NUM-1:0]    cand_ext;
    logic [1:0]                    kw_pos;
    ael_pkg::t_run_mode            post_mode;
    logic [ael_pkg::POS_BITS-1:0]  post_start;
    logic [15:0]                   post_len;
    logic [ael_pkg::KW_NUM-1:0]    post_cand;
    logic [1:0]                    n_tok;

    assign adv        = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || adv;
    assign c          = r_in.in_byte;
    assign eos        = r_in.end_of_stream;

    // classification and post-byte run
    always_comb begin
        c_digit = is_digit(c);
        c_lower = is_lower(c);
        is_op   = 1'b1;
        case (c)
            ael_pkg::CH_PLUS:  op_kind = ael_pkg::KIND_PLUS;
            ael_pkg::CH_MINUS: op_kind = ael_pkg::KIND_MINUS;
            ael_pkg::CH_STAR:  op_kind = ael_pkg::KIND_MUL;
            ael_pkg::CH_SLASH: op_kind = ael_pkg::KIND_DIV;
            ael_pkg::CH_LPAR:  op_kind = ael_pkg::KIND_LPAREN;
            ael_pkg::CH_RPAR:  op_kind = ael_pkg::KIND_RPAREN;
            default: begin
                op_kind = ael_pkg::KIND_PLUS;
                is_op   = 1'b0;
            end
        endcase

        kw_pos = (r_run_len < 16'(ael_pkg::KW_CHARS)) ? r_run_len[1:0] : 2'd0;
        for (int i = 0; i < ael_pkg::KW_NUM; i++) begin
            cand_ext[i] = r_cand[i] && (r_run_len < 16'(ael_pkg::KW_LEN[i]))
                          && (ael_pkg::KW_TEXT[i][kw_pos] == c);
        end

        extended = ((r_mode == ael_pkg::RUN_NUMBER) && (c_digit || c == ael_pkg::CH_DOT))
                || ((r_mode == ael_pkg::RUN_WORD) && c_lower);
        close_old = !extended
                 && ((r_mode == ael_pkg::RUN_NUMBER) || (r_mode == ael_pkg::RUN_WORD));
        op_emit   = !extended && is_op;

        if (extended) begin
            post_mode  = r_mode;
            post_start = r_run_start;
            post_len   = (r_run_len == ael_pkg::LEN_MAX) ? r_run_len : r_run_len + 16'd1;
            post_cand  = (r_mode == ael_pkg::RUN_WORD) ? cand_ext : r_cand;
        end else if (!is_op && (c_digit || c_lower)) begin
            post_mode  = c_digit ? ael_pkg::RUN_NUMBER : ael_pkg::RUN_WORD;
            post_start = r_pos;
            post_len   = 16'd1;
            post_cand  = c_digit ? ael_pkg::CAND_ALL : first_cand(c);
        end else begin
            post_mode  = ael_pkg::RUN_NONE;
            post_start = r_run_start;
            post_len   = 16'd0;
            post_cand  = ael_pkg::CAND_ALL;
        end

        close_new = eos && ((post_mode == ael_pkg::RUN_NUMBER)
                         || (post_mode == ael_pkg::RUN_WORD));
        n_tok = 2'(close_old) + 2'(op_emit) + 2'(close_new);
    end

    // next state
    always_comb begin
        n_run_start = post_start;
        if (eos) begin
            n_mode    = ael_pkg::RUN_NONE;
            n_run_len = 16'd0;
            n_cand    = ael_pkg::CAND_ALL;
            n_pos     = '0;
            n_tok_cnt = 16'd0;
        end else begin
            n_mode    = post_mode;
            n_run_len = post_len;
            n_cand    = post_cand;
            n_pos     = r_pos + 1'b1;
            n_tok_cnt = r_tok_cnt + 16'(n_tok);
        end
    end

    // token outputs
    always_comb begin
        ael_pkg::t_out_item tok_a;
        ael_pkg::t_out_item tok_b;
        ael_pkg::t_out_item tok_c;
        tok_a = run_tok(r_mode, r_cand, r_run_start, r_run_len);
        tok_b = make_tok(op_kind, r_pos, 16'd1, 1'b1);
        tok_c = run_tok(post_mode, post_cand, post_start, post_len);

        o_pair.valid = adv && (n_tok != 2'd0);
        o_pair.pair  = (n_tok == 2'd2);
        o_pair.tok0  = close_old ? tok_a : (op_emit ? tok_b : tok_c);
        o_pair.tok1  = (close_old && op_emit) ? tok_b : tok_c;
        o_pair.tok0.token_ordinal = r_tok_cnt;
        o_pair.tok1.token_ordinal = r_tok_cnt + 16'd1;
        o_pair.tok0.last_of_run   = (n_tok != 2'd2);
        o_pair.tok1.last_of_run   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_mode      <= ael_pkg::RUN_NONE;
            r_run_start <= '0;
            r_run_len   <= 16'd0;
            r_cand      <= ael_pkg::CAND_ALL;
            r_pos       <= '0;
            r_tok_cnt   <= 16'd0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_mode      <= n_mode;
                r_run_start <= n_run_start;
                r_run_len   <= n_run_len;
                r_cand      <= n_cand;
                r_pos       <= n_pos;
                r_tok_cnt   <= n_tok_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

endmodule

/* rtl/core/ael_tok_fifo.sv */
// ----------------------------------------------------------------------------
// ael_tok_fifo
// Result queue of token pairs; drains one token per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module ael_tok_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ael_pkg::t_tok_pair  i_pair,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ael_pkg::t_out_item  o_out_data
);

    ael_pkg::t_tok_pair              r_mem [ael_pkg::TOK_DEPTH];
    logic [ael_pkg::PTR_BITS-1:0]    r_wr_ptr;
    logic [ael_pkg::PTR_BITS-1:0]    r_rd_ptr;
    logic [ael_pkg::PTR_BITS:0]      r_count;
    logic                            r_half;

    ael_pkg::t_tok_pair              head;
    logic                            pop;
    logic                            entry_done;

    function automatic logic [ael_pkg::PTR_BITS-1:0] ptr_inc(
        input logic [ael_pkg::PTR_BITS-1:0] p);
        if (p == ael_pkg::PTR_BITS'(ael_pkg::TOK_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign head        = r_mem[r_rd_ptr];
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_half ? head.tok1 : head.tok0;
    assign o_room      = (r_count < (ael_pkg::PTR_BITS + 1)'(ael_pkg::TOK_DEPTH));
    assign pop         = o_out_valid && i_out_ready;
    assign entry_done  = pop && (r_half || !head.pair);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_half   <= 1'b0;
        end else begin
            if (i_pair.valid) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (entry_done) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
                r_half   <= 1'b0;
            end else if (pop) begin
                r_half   <= 1'b1;
            end
            r_count <= r_count + (ael_pkg::PTR_BITS + 1)'(i_pair.valid)
                               - (ael_pkg::PTR_BITS + 1)'(entry_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pair.valid) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

endmodule

/* rtl/core/arith_expression_lexer.sv */
// ----------------------------------------------------------------------------
// arith_expression_lexer
// Byte-stream tokenizer for arithmetic expressions.
// ----------------------------------------------------------------------------
// Takes one byte per transaction and emits tokens: + - * / ( ) as operators,
// digit-led runs of digits and dots as numbers, lowercase runs as the
// functions sin cos tan exp log (ln also gives log; unknown words give sin
// with word_recognized low). All other bytes are skipped. end_of_stream on a
// byte flushes any open run and restarts position and ordinal counting. A
// byte can produce up to two tokens (closing a run plus an operator, or a
// run flush on end_of_stream); last_of_run marks the final one. Bytes are
// taken one per cycle while the result queue has room; each byte is held
// in the input register and its tokens are then written into a two-entry
// result queue. The output side delivers one token per cycle while the
// consumer is ready; a byte that yields two tokens holds it for both, so
// that port bounds the sustained rate when operators follow runs closely.
// ----------------------------------------------------------------------------
module arith_expression_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ael_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ael_pkg::t_out_item o_out_data
);

    // token pair from the step logic into the queue
    ael_pkg::t_tok_pair pair;
    // queue can take another pair this cycle
    logic               room;

    // Input register, run state machine and per-byte token decode.
    ael_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_room     (room),
        .o_pair     (pair)
    );

    // Result queue: holds finished tokens so the input side keeps moving while
    // the consumer stalls, until the queue is full.
    ael_tok_fifo u_tok_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (pair),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/ael_checker.sv */
// ----------------------------------------------------------------------------
// ael_checker
// Port-level assertions for the expression lexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ael_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  ael_pkg::t_out_item o_out_data
);

    `AEL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data),
        "stalled token dropped or changed")

    `AEL_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n,
        o_out_valid, o_out_data.token_length != 16'd0,
        "token with zero length")

    `AEL_ASSERT_IMP(a_op_single, i_clk, i_rst_n,
        o_out_valid && (o_out_data.token_kind <= ael_pkg::KIND_RPAREN),
        (o_out_data.token_length == 16'd1) && o_out_data.word_recognized,
        "operator token not one byte")

    `AEL_ASSERT_IMP(a_num_recognized, i_clk, i_rst_n,
        o_out_valid && (o_out_data.token_kind == ael_pkg::KIND_NUMBER),
        o_out_data.word_recognized && (o_out_data.token_length != 16'd0),
        "number token malformed")

    // input only backs up behind a full result queue
    `AEL_ASSERT_IMP(a_in_blocked, i_clk, i_rst_n,
        !o_in_ready, o_out_valid,
        "input blocked with no token waiting")

endmodule

bind arith_expression_lexer ael_checker u_ael_checker (.*);
